FILE: rtl/sld_pkg.sv
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync word / length prefixed deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int SYNC_W   = 32;
    localparam int HLEN_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_WORD     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_LENGTH = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [SYNC_W-1:0] SYNC_WORD_RST     = 32'hFAFA_F0F0;
    localparam logic [HLEN_W-1:0] HEADER_LENGTH_RST = 8'd8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC = 2'd2;

    // Result burst handed from the frame tracker to the output register.
    // The bytes to send sit in word, first byte in the top bits; the offset
    // counts up by one for each byte sent.
    typedef struct packed {
        logic [CNT_W-1:0]    cnt;
        logic [SYNC_W-1:0]   word;
        logic [OFFSET_W-1:0] offset;
        logic                last;
        logic [STATUS_W-1:0] status;
    } burst_t;

endpackage

FILE: rtl/sld_core.sv
// ----------------------------------------------------------------------------
// sld_core
// Frame tracker: sync hunt window, frame counters and configuration
// registers. Turns each consumed item into a burst of zero to four results.
// ----------------------------------------------------------------------------
module sld_core
    import sld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SYNC_W-1:0]    cfg_wdata,
    input  logic                 consume,
    input  logic [BYTE_W-1:0]    item_byte,
    input  logic                 item_eos,
    output burst_t               burst
);

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_LENGTH  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    logic [SYNC_W-1:0]   sync_word_reg;
    logic [HLEN_W-1:0]   header_length_reg;
    logic [1:0]          phase_reg, phase_next;
    logic [23:0]         recent_reg, recent_next;
    logic [1:0]          fill_reg, fill_next;
    logic [OFFSET_W-1:0] pos_reg, pos_next;
    logic [OFFSET_W-1:0] total_reg, total_next;

    logic [SYNC_W-1:0]   window;
    logic [OFFSET_W-1:0] pos_inc;
    logic [OFFSET_W-1:0] length_total;
    logic [OFFSET_W:0]   header_end;

    assign window       = {recent_reg, item_byte};
    assign pos_inc      = pos_reg + 16'd1;
    assign length_total = {total_reg[15:8], item_byte};
    assign header_end   = 17'd4 + {9'd0, header_length_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        recent_next = recent_reg;
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        total_next  = total_reg;
        burst       = '0;
        burst.word  = {item_byte, 24'd0};
        burst.offset = pos_reg;
        burst.status = ST_OK;

        if (item_eos)
        begin
            if (phase_reg != PH_HUNT)
            begin
                burst.cnt    = 3'd1;
                burst.word   = '0;
                burst.last   = 1'b1;
                burst.status = ST_TRUNC;
            end
            phase_next  = PH_HUNT;
            recent_next = '0;
            fill_next   = '0;
            pos_next    = '0;
            total_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (fill_reg == 2'd3 && window == sync_word_reg)
                    begin
                        burst.cnt    = 3'd4;
                        burst.word   = window;
                        burst.offset = '0;
                        pos_next     = 16'd4;
                        total_next   = '0;
                        recent_next  = '0;
                        fill_next    = '0;
                        phase_next   = (header_length_reg != '0) ? PH_HEADER : PH_LENGTH;
                    end
                    else
                    begin
                        recent_next = window[23:0];
                        if (fill_reg != 2'd3)
                        begin
                            fill_next = fill_reg + 2'd1;
                        end
                    end
                end
                PH_HEADER:
                begin
                    burst.cnt = 3'd1;
                    pos_next  = pos_inc;
                    if ({1'b0, pos_inc} >= header_end)
                    begin
                        phase_next = PH_LENGTH;
                        fill_next  = '0;
                    end
                end
                PH_LENGTH:
                begin
                    burst.cnt = 3'd1;
                    if (fill_reg == 2'd0)
                    begin
                        total_next = {item_byte, 8'd0};
                        pos_next   = pos_inc;
                        fill_next  = 2'd1;
                    end
                    else if (length_total <= pos_inc)
                    begin
                        // Frame ends on its length field; too short is an error.
                        burst.last   = 1'b1;
                        burst.status = (length_total < pos_inc) ? ST_SHORT : ST_OK;
                        phase_next   = PH_HUNT;
                        recent_next  = '0;
                        fill_next    = '0;
                        pos_next     = '0;
                        total_next   = '0;
                    end
                    else
                    begin
                        total_next = length_total;
                        pos_next   = pos_inc;
                        fill_next  = '0;
                        phase_next = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    burst.cnt = 3'd1;
                    if (pos_inc >= total_reg)
                    begin
                        burst.last  = 1'b1;
                        phase_next  = PH_HUNT;
                        recent_next = '0;
                        fill_next   = '0;
                        pos_next    = '0;
                        total_next  = '0;
                    end
                    else
                    begin
                        pos_next = pos_inc;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_word_reg     <= SYNC_WORD_RST;
            header_length_reg <= HEADER_LENGTH_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_SYNC_WORD:     sync_word_reg     <= cfg_wdata;
                REG_HEADER_LENGTH: header_length_reg <= cfg_wdata[HLEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            recent_reg <= '0;
            fill_reg   <= '0;
            pos_reg    <= '0;
            total_reg  <= '0;
        end
        else if (consume)
        begin
            phase_reg  <= phase_next;
            recent_reg <= recent_next;
            fill_reg   <= fill_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
        end
    end

endmodule

FILE: rtl/sld_outreg.sv
// ----------------------------------------------------------------------------
// sld_outreg
// Result register: holds a burst of up to four results and sends them one
// item per cycle on the output stream while the receiver is ready.
// ----------------------------------------------------------------------------
module sld_outreg
    import sld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  burst_t               burst,
    output logic                 can_load,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tlast,
    output logic [STATUS_W-1:0]  m_tuser
);

    logic [CNT_W-1:0]    cnt_reg;
    logic [SYNC_W-1:0]   word_reg;
    logic [OFFSET_W-1:0] offset_reg;
    logic                last_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                fire;

    assign fire     = (cnt_reg != '0) && m_tready;
    // A new burst may be loaded once the register is empty or its final
    // result leaves in this cycle.
    assign can_load = (cnt_reg == '0) || (cnt_reg == 3'd1 && m_tready);

    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {offset_reg, word_reg[31:24]};
    // Only a single-result burst can carry the frame end mark.
    assign m_tlast  = last_reg;
    assign m_tuser  = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= burst.cnt;
        end
        else if (fire)
        begin
            cnt_reg <= cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg   <= burst.word;
            offset_reg <= burst.offset;
            last_reg   <= burst.last;
            status_reg <= burst.status;
        end
        else if (fire)
        begin
            word_reg   <= {word_reg[23:0], 8'd0};
            offset_reg <= offset_reg + 16'd1;
        end
    end

endmodule

FILE: rtl/sync_length_deframer.sv
// ----------------------------------------------------------------------------
// sync_length_deframer
// Cuts a byte stream into frames that open with a sync word, a header and a
// big-endian 16-bit total length, and passes the frame bytes with offsets.
// ----------------------------------------------------------------------------
// An item is captured in the input register when it is accepted; its burst
// loads the result register once that register can take it, and its
// results are then offered on the output. Throughput: one item per cycle
// while the output is ready; a sync match gives four results, which hold off
// the next item while the result register drains them.
// Reset (rst_n, asynchronous, active low) clears the frame tracker to sync
// hunting with an empty window and loads the configuration reset values.
// ----------------------------------------------------------------------------
module sync_length_deframer
    import sld_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    // Configuration write port: index 0 is the sync word, index 1 the
    // header length.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SYNC_W-1:0]    cfg_wdata,

    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] byte_value
    input  logic                 s_tuser,   // [0] end_of_stream

    // Output stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [7:0] frame_byte, [23:8] byte_offset
    output logic                 m_tlast,   // frame_last
    output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

    // The input register holds one item, so an item is taken in even while
    // a finished result still waits on the output side.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eos_reg;

    logic   can_load;
    logic   consume;
    burst_t burst;

    // The buffered item is processed when the result register can take its
    // burst; the frame tracker state and the result register update together.
    assign consume  = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tuser;
        end
    end

    // Hunt window, frame counters and configuration registers.
    sld_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .consume   (consume),
        .item_byte (in_byte_reg),
        .item_eos  (in_eos_reg),
        .burst     (burst)
    );

    // Result register that spreads a burst over consecutive output items.
    sld_outreg u_outreg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (consume),
        .burst    (burst),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: bench/tb_sync_length_deframer.sv
// ----------------------------------------------------------------------------
// tb_sync_length_deframer
// Self-checking bench for the sync word / length prefixed deframer. A queue
// of stream items feeds a driver with random gaps, a frame tracker in the
// bench predicts every result, and a monitor with random back-pressure
// compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sync_length_deframer
    import sld_pkg::*;
();

    // Phases of the bench's own frame tracker.
    typedef enum logic [1:0] {
        TRK_HUNT,
        TRK_HEADER,
        TRK_LENGTH,
        TRK_PAYLOAD
    } trk_phase_t;

    // One input item: a stream byte or an end-of-stream marker.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              eos;
    } stream_item_t;

    // One output item as the deframer should present it.
    typedef struct packed {
        logic [BYTE_W-1:0]   fbyte;
        logic [OFFSET_W-1:0] offset;
        logic                last;
        logic [STATUS_W-1:0] status;
    } frame_result_t;

    // ------------------------------------------------------------------------
    // Block ports. Every input holds a known value from time zero.
    // ------------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SYNC_WORD;
    logic [SYNC_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;    // [7:0] byte_value
    logic                 s_tuser = 1'b0;  // [0] end_of_stream
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [23:0]          m_tdata;         // [7:0] frame_byte, [23:8] byte_offset
    logic                 m_tlast;         // frame_last
    logic [STATUS_W-1:0]  m_tuser;         // [1:0] status

    sync_length_deframer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------
    stream_item_t  stream_items[$];     // items waiting for the driver
    frame_result_t frame_results_due[$];// predicted results, oldest first
    stream_item_t  next_item;
    frame_result_t due;
    frame_result_t seen;
    int            errors = 0;
    int            frame_items = 0;     // items sent that belong to a frame
    bit            full_rate = 1'b0;    // both sides run without idling
    bit            item_taken = 1'b0;   // driver's item was accepted this cycle

    // Shadow configuration, updated together with each register write.
    logic [SYNC_W-1:0] sync_cfg = SYNC_WORD_RST;
    logic [HLEN_W-1:0] hdr_cfg  = HEADER_LENGTH_RST;

    // Shadow frame tracker state.
    trk_phase_t          trk_phase = TRK_HUNT;
    logic [23:0]         recent = '0;    // last three hunted bytes, newest lowest
    logic [1:0]          fill = '0;      // window fill, or length bytes taken
    logic [OFFSET_W-1:0] position = '0;  // offset of the next frame byte
    logic [OFFSET_W-1:0] announced = '0; // total length the frame announced

    // ------------------------------------------------------------------------
    // Frame tracker prediction.
    // ------------------------------------------------------------------------
    function automatic void add_result(input logic [BYTE_W-1:0] b,
                                       input logic [OFFSET_W-1:0] off,
                                       input logic last,
                                       input logic [STATUS_W-1:0] st);
        frame_results_due.push_back('{fbyte: b, offset: off, last: last, status: st});
    endfunction

    function automatic void restart_hunt();
        trk_phase = TRK_HUNT;
        recent    = '0;
        fill      = '0;
        position  = '0;
        announced = '0;
    endfunction

    // Advances the shadow tracker by one accepted item and queues the results
    // that the item causes.
    function automatic void deframe_item(input logic [BYTE_W-1:0] b, input logic eos);
        logic [31:0]         word;
        logic [OFFSET_W-1:0] off;
        logic [OFFSET_W-1:0] fixed_end;
        int                  k;

        // End of stream: a frame in progress is closed as truncated at the
        // offset that was due next; a half-filled window is simply dropped.
        if (eos)
        begin
            if (trk_phase != TRK_HUNT)
                add_result('0, position, 1'b1, ST_TRUNC);
            restart_hunt();
            return;
        end

        case (trk_phase)
            TRK_HUNT:
            begin
                word = {recent, b};
                if (fill == 2'd3 && word == sync_cfg)
                begin
                    // The four sync bytes go out at offsets 0 to 3.
                    for (k = 0; k < 4; k++)
                        add_result(word[31 - 8 * k -: 8], OFFSET_W'(k), 1'b0, ST_OK);
                    position  = 16'd4;
                    announced = '0;
                    recent    = '0;
                    fill      = '0;
                    trk_phase = (hdr_cfg != 0) ? TRK_HEADER : TRK_LENGTH;
                end
                else
                begin
                    recent = word[23:0];
                    if (fill != 2'd3)
                        fill = fill + 2'd1;
                end
            end
            TRK_HEADER:
            begin
                // The end of header check follows each byte, so a header
                // length lowered mid-frame still lets one byte through.
                add_result(b, position, 1'b0, ST_OK);
                position = position + 16'd1;
                if (32'(position) >= 32'd4 + 32'(hdr_cfg))
                begin
                    trk_phase = TRK_LENGTH;
                    fill      = '0;
                end
            end
            TRK_LENGTH:
            begin
                if (fill == 2'd0)
                begin
                    add_result(b, position, 1'b0, ST_OK);
                    announced = {b, 8'h00};
                    position  = position + 16'd1;
                    fill      = 2'd1;
                end
                else
                begin
                    // A total below the fixed part ends the frame with an
                    // error; a total equal to it ends the frame cleanly.
                    off       = position;
                    fixed_end = position + 16'd1;
                    announced = {announced[15:8], b};
                    if (announced < fixed_end)
                    begin
                        add_result(b, off, 1'b1, ST_SHORT);
                        restart_hunt();
                    end
                    else if (announced == fixed_end)
                    begin
                        add_result(b, off, 1'b1, ST_OK);
                        restart_hunt();
                    end
                    else
                    begin
                        add_result(b, off, 1'b0, ST_OK);
                        position  = fixed_end;
                        fill      = '0;
                        trk_phase = TRK_PAYLOAD;
                    end
                end
            end
            default:
            begin
                off      = position;
                position = position + 16'd1;
                if (position >= announced)
                begin
                    add_result(b, off, 1'b1, ST_OK);
                    restart_hunt();
                end
                else
                begin
                    add_result(b, off, 1'b0, ST_OK);
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial
    begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver. Inputs change at the falling edge only. An item stays on the bus
    // until it is accepted; after that the next one follows at once or after a
    // random gap.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || item_taken)
        begin
            if (stream_items.size() != 0 && (full_rate || $urandom_range(0, 99) >= 31))
            begin
                next_item = stream_items.pop_front();
                s_tdata  <= next_item.value;
                s_tuser  <= next_item.eos;
                s_tvalid <= 1'b1;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // Every item accepted at a rising edge goes through the shadow tracker.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            deframe_item(s_tdata, s_tuser);
            item_taken = 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver back-pressure and result check.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        m_tready <= rst_n && (full_rate || $urandom_range(0, 99) >= 31);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = '{fbyte: m_tdata[7:0], offset: m_tdata[23:8], last: m_tlast,
                     status: m_tuser};
            if (frame_results_due.size() == 0)
            begin
                errors++;
                $display({"%0t: unexpected item: expected none, got byte %02h ",
                          "offset %0d last %0b status %0d"},
                         $time, seen.fbyte, seen.offset, seen.last, seen.status);
            end
            else
            begin
                due = frame_results_due.pop_front();
                if (seen.fbyte !== due.fbyte || seen.offset !== due.offset ||
                    seen.last !== due.last || seen.status !== due.status)
                begin
                    errors++;
                    $display({"%0t: item mismatch: expected byte %02h offset %0d ",
                              "last %0b status %0d, got byte %02h offset %0d ",
                              "last %0b status %0d"},
                             $time, due.fbyte, due.offset, due.last, due.status,
                             seen.fbyte, seen.offset, seen.last, seen.status);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void queue_item(input logic [BYTE_W-1:0] v, input logic eos,
                                       input bit in_frame);
        stream_items.push_back('{value: v, eos: eos});
        if (in_frame)
            frame_items++;
    endfunction

    function automatic void queue_noise(input int count);
        repeat (count) queue_item(BYTE_W'($urandom_range(0, 255)), 1'b0, 1'b0);
    endfunction

    // Queues one frame built for the current configuration. When cut is set
    // the frame is broken off by an end of stream somewhere inside it, and
    // the announced length may then be anything at all.
    function automatic void queue_frame(input bit cut);
        int                  fixed_len;
        int                  frame_len;
        int                  count;
        int                  i;
        int                  r;
        logic [OFFSET_W-1:0] total;
        logic [BYTE_W-1:0]   v;

        fixed_len = 6 + int'(hdr_cfg);
        r = $urandom_range(0, 99);
        if (cut && r < 50)
            total = OFFSET_W'($urandom_range(0, 65535));
        else if (r < 12)
            total = OFFSET_W'($urandom_range(0, fixed_len - 1));
        else if (r < 22)
            total = OFFSET_W'(fixed_len);
        else if (r < 90)
            total = OFFSET_W'(fixed_len + $urandom_range(1, 12));
        else
            total = OFFSET_W'(fixed_len + $urandom_range(13, 48));
        frame_len = (int'(total) > fixed_len) ? int'(total) : fixed_len;
        if (cut)
            count = $urandom_range(1, (frame_len < fixed_len + 16) ? frame_len - 1
                                                                   : fixed_len + 16);
        else
            count = frame_len;

        // A little line noise ahead of the sync word now and then.
        if ($urandom_range(0, 3) == 0)
            queue_noise($urandom_range(1, 3));

        for (i = 0; i < count; i++)
        begin
            if (i < 4)
                v = sync_cfg[31 - 8 * i -: 8];
            else if (i == 4 + int'(hdr_cfg))
                v = total[15:8];
            else if (i == 5 + int'(hdr_cfg))
                v = total[7:0];
            else
                v = BYTE_W'($urandom_range(0, 255));
            queue_item(v, 1'b0, 1'b1);
        end
        if (cut)
            queue_item(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
    endfunction

    // Writes both registers on consecutive cycles. The header length write
    // carries random bits above the register width.
    task automatic program_regs(input logic [SYNC_W-1:0] sync_val,
                                input logic [HLEN_W-1:0] hdr_val);
        logic [SYNC_W-1:0] filler;

        filler = $urandom;
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_SYNC_WORD;
        cfg_wdata <= sync_val;
        sync_cfg  = sync_val;
        @(negedge clk);
        cfg_index <= REG_HEADER_LENGTH;
        cfg_wdata <= {filler[SYNC_W-1:HLEN_W], hdr_val};
        hdr_cfg   = hdr_val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every queued item has been taken and every predicted result
    // has come out, then lets the pipeline settle, since hunting bytes give no
    // result that could be waited for.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (stream_items.size() != 0 || s_tvalid || frame_results_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        // Directed items with an empty header and the reset sync word; bit 8
        // marks an end of stream. They cover a sync word at the very start of
        // the stream, a total equal to the fixed part, a total below it, a
        // one-byte payload, a frame truncated inside its length field, and an
        // end of stream while hunting.
        logic [8:0]        directed[$] = '{
            9'h0FA, 9'h0FA, 9'h0F0, 9'h0F0, 9'h000, 9'h006,
            9'h0FA, 9'h0FA, 9'h0F0, 9'h0F0, 9'h000, 9'h000,
            9'h0FA, 9'h0FA, 9'h0F0, 9'h0F0, 9'h000, 9'h007, 9'h0FF,
            9'h0FA, 9'h0FA, 9'h0F0, 9'h0F0, 9'h0FF, 9'h100,
            9'h1FF
        };
        logic [SYNC_W-1:0] sync_val;
        logic [HLEN_W-1:0] hdr_val;
        int                ph;
        int                start_count;
        int                r;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        program_regs(SYNC_WORD_RST, 8'd0);
        foreach (directed[i])
            queue_item(directed[i][7:0], directed[i][8], 1'b1);
        wait_drained();

        // Random phases, each under its own configuration. The second and
        // third use the extreme sync words, the third also the longest
        // header; the fourth runs longer and with no idling on either side.
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph)
                1:
                begin
                    sync_val = '0;
                    hdr_val  = 8'd0;
                end
                2:
                begin
                    sync_val = '1;
                    hdr_val  = 8'd255;
                end
                4:
                begin
                    sync_val = SYNC_WORD_RST;
                    hdr_val  = HEADER_LENGTH_RST;
                end
                6:
                begin
                    sync_val = $urandom;
                    hdr_val  = 8'd1;
                end
                default:
                begin
                    sync_val = $urandom;
                    hdr_val  = HLEN_W'($urandom_range(0, 6));
                end
            endcase
            program_regs(sync_val, hdr_val);
            full_rate = (ph == 3);

            // A frame left open by the previous phase now runs on under the
            // new header length until an end of stream closes it.
            if (trk_phase != TRK_HUNT)
            begin
                queue_noise($urandom_range(1, 6));
                queue_item(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b1);
            end

            start_count = frame_items;
            while (frame_items - start_count < ((ph == 3) ? 24 : 10))
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    queue_frame(1'b0);
                end
                else if (r < 85)
                begin
                    queue_frame(1'b1);
                end
                else
                begin
                    queue_noise($urandom_range(1, 5));
                    if (r < 92)
                        queue_item(BYTE_W'($urandom_range(0, 255)), 1'b1, 1'b0);
                end
            end

            // Now and then leave a partial frame or a few hunted bytes behind, so
            // that the next register writes land mid-frame or mid-hunt.
            r = $urandom_range(0, 2);
            if (r == 1)
            begin
                for (int i = 0; i < 4; i++)
                    queue_item(sync_cfg[31 - 8 * i -: 8], 1'b0, 1'b1);
                queue_noise($urandom_range(0, 2));
            end
            else if (r == 2)
            begin
                queue_noise(2);
            end
            wait_drained();
        end
        full_rate = 1'b0;

        if (errors == 0)
            $display("sync_length_deframer test passed");
        else
            $display("sync_length_deframer test failed");
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial
    begin
        #1_000_000;
        $display("sync_length_deframer test failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/sld_pkg.sv
rtl/sld_core.sv
rtl/sld_outreg.sv
rtl/sync_length_deframer.sv
bench/tb_sync_length_deframer.sv
